/* sv/hsf_pkg.sv */
// hsf_pkg: shared types, register indexes and Q16.16 saturating arithmetic
// used by the hyperelastic sample force pipeline; no dependencies
package hsf_pkg;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic signed [31:0] def_00;
    logic signed [31:0] def_01;
    logic signed [31:0] def_10;
    logic signed [31:0] def_11;
    logic signed [31:0] rate_00;
    logic signed [31:0] rate_01;
    logic signed [31:0] rate_10;
    logic signed [31:0] rate_11;
    logic [30:0]        weight;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_00;
    logic signed [31:0] force_01;
    logic signed [31:0] force_10;
    logic signed [31:0] force_11;
    logic signed [31:0] energy_term;
  } out_item_t;

  typedef struct packed {
    logic [30:0] mu_coef;
    logic [30:0] lambda_coef;
    logic [30:0] alpha_coef;
    logic [30:0] beta_coef;
    logic        damping_on;
  } cfg_t;

  localparam logic [2:0] REG_MU      = 3'd0;
  localparam logic [2:0] REG_LAMBDA  = 3'd1;
  localparam logic [2:0] REG_ALPHA   = 3'd2;
  localparam logic [2:0] REG_BETA    = 3'd3;
  localparam logic [2:0] REG_DAMPING = 3'd4;

  localparam q_t Q_ONE  = 32'sh0001_0000;
  localparam q_t Q_HALF = 32'sh0000_8000;
  localparam q_t Q_MAX  = 32'sh7fff_ffff;
  localparam q_t Q_MIN  = 32'sh8000_0000;

  function automatic q_t sat34(input logic signed [33:0] x);
    q_t r;
    if (x > 34'sh0_7fff_ffff) r = Q_MAX;
    else if (x < -34'sh0_8000_0000) r = Q_MIN;
    else r = x[31:0];
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    return sat34(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [33:0] s;
    s = 34'(a) - 34'(b);
    return sat34(s);
  endfunction

  function automatic q_t qneg(input q_t a);
    logic signed [33:0] s;
    s = -34'(a);
    return sat34(s);
  endfunction

  function automatic q_t qtwice(input q_t a);
    logic signed [33:0] s;
    s = 34'(a) <<< 1;
    return sat34(s);
  endfunction

  // round half up: floor((p + 2^15) / 2^16), then saturate
  function automatic q_t qmul(input q_t a, input q_t b);
    logic signed [64:0] p;
    logic signed [48:0] q;
    p = 65'(a) * 65'(b) + 65'sd32768;
    q = p[64:16];
    if (q > 49'sh0_7fff_ffff) return Q_MAX;
    else if (q < -49'sh0_8000_0000) return Q_MIN;
    else return q[31:0];
  endfunction

  function automatic q_t qhalf(input q_t a);
    return qmul(a, Q_HALF);
  endfunction

endpackage

/* sv/hyperelastic_2d_sample_force.sv */
// hyperelastic_2d_sample_force: top level, config registers plus the
// seven-stage force pipeline; depends on hsf_pkg, hsf_cfg_regs, hsf_datapath
//
// Usage: each item on in_* is one sampling point (F, dF/dt, weight). The
// block returns one item on out_* with four saturated force terms and the
// weighted elastic energy, all Q16.16.
// Path: an accepted item is registered through stages 1 to 7 in order, and
// out_valid is the valid bit of stage 7.
// Throughput: one item per cycle while no stall holds the pipeline; the whole
// pipeline steps together and the last stage is the output register.
// Stall: when out_ready is low with a result waiting, every stage holds,
// empty ones included, in_ready falls and nothing is lost or repeated.
// Config: cfg_* writes are taken every cycle; coefficients are read in
// several stages, so write them only while the pipeline is empty.
// Reset (rst, synchronous): registers take their defaults (alpha 1.0,
// damping off), all stage valid bits clear.
module hyperelastic_2d_sample_force (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hsf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hsf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import hsf_pkg::*;

  cfg_t cfg;
  logic advance;

  assign advance  = out_ready | ~out_valid;
  assign in_ready = advance;

  hsf_cfg_regs u_regs (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
  );

  hsf_datapath u_dp (
    .clk, .rst, .advance, .in_valid, .in_item(in_data), .cfg,
    .out_valid, .out_item(out_data)
  );
endmodule

/* sv/hsf_cfg_regs.sv */
// hsf_cfg_regs: coefficient register file written through the config channel
// depends on hsf_pkg
module hsf_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  output hsf_pkg::cfg_t cfg
);
  import hsf_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mu_coef     <= '0;
      cfg.lambda_coef <= '0;
      cfg.alpha_coef  <= Q_ONE[30:0];
      cfg.beta_coef   <= '0;
      cfg.damping_on  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MU:      cfg.mu_coef     <= cfg_data[30:0];
        REG_LAMBDA:  cfg.lambda_coef <= cfg_data[30:0];
        REG_ALPHA:   cfg.alpha_coef  <= cfg_data[30:0];
        REG_BETA:    cfg.beta_coef   <= cfg_data[30:0];
        REG_DAMPING: cfg.damping_on  <= cfg_data[0];
        default: ;
      endcase
    end
  end
endmodule

/* sv/hsf_datapath.sv */
// hsf_datapath: seven-stage stallable arithmetic pipeline, at most one multiply
// level per stage; depends on hsf_pkg
module hsf_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              in_valid,
  input  hsf_pkg::in_item_t in_item,
  input  hsf_pkg::cfg_t     cfg,
  output logic              out_valid,
  output hsf_pkg::out_item_t out_item
);
  import hsf_pkg::*;

  localparam int Stages = 7;
  logic [Stages-1:0] vld;

  q_t mu, lam, alpha, beta;
  assign mu    = {1'b0, cfg.mu_coef};
  assign lam   = {1'b0, cfg.lambda_coef};
  assign alpha = {1'b0, cfg.alpha_coef};
  assign beta  = {1'b0, cfg.beta_coef};

  // stage 1: products of inputs
  q_t s1_f[4], s1_w, s1_ff03, s1_ff12, s1_mf[4], s1_sq[4], s1_fr[8], s1_wb, s1_mua;
  // stage 2
  q_t s2_f[4], s2_w, s2_dec, s2_mf[4], s2_n, s2_half[4], s2_a, s2_b, s2_wb, s2_mua;
  // stage 3
  q_t s3_f[4], s3_w, s3_ld, s3_mf[4], s3_nmu, s3_dd, s3_s, s3_a, s3_b, s3_wb, s3_mua;
  // stage 4
  q_t s4_w, s4_p[4], s4_fa[4], s4_fs[4], s4_wb, s4_e0;
  // stage 5
  q_t s5_w, s5_p[4], s5_d[4], s5_wb, s5_e;
  // stage 6
  q_t s6_f[4], s6_wd[4], s6_we;
  // stage 7
  q_t s7_f[4], s7_e;
  logic [5:0] damp;

  // mu*(1+alpha) travels alongside until stage 5
  q_t s3_mua_d;

  q_t s1_ld_ab;
  assign s1_ld_ab = qadd(Q_ONE, alpha);

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (advance) vld <= {vld[Stages-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      damp <= {damp[4:0], cfg.damping_on};
      // stage 1
      s1_f[0] <= in_item.def_00;
      s1_f[1] <= in_item.def_01;
      s1_f[2] <= in_item.def_10;
      s1_f[3] <= in_item.def_11;
      s1_w    <= {1'b0, in_item.weight};
      s1_ff03 <= qmul(in_item.def_00, in_item.def_11);
      s1_ff12 <= qmul(in_item.def_01, in_item.def_10);
      s1_mf[0] <= qmul(mu, in_item.def_00);
      s1_mf[1] <= qmul(mu, in_item.def_01);
      s1_mf[2] <= qmul(mu, in_item.def_10);
      s1_mf[3] <= qmul(mu, in_item.def_11);
      s1_sq[0] <= qmul(in_item.def_00, in_item.def_00);
      s1_sq[1] <= qmul(in_item.def_01, in_item.def_01);
      s1_sq[2] <= qmul(in_item.def_10, in_item.def_10);
      s1_sq[3] <= qmul(in_item.def_11, in_item.def_11);
      s1_fr[0] <= qmul(in_item.def_00, in_item.rate_01);
      s1_fr[1] <= qmul(in_item.def_01, in_item.rate_00);
      s1_fr[2] <= qmul(in_item.def_10, in_item.rate_11);
      s1_fr[3] <= qmul(in_item.def_11, in_item.rate_10);
      s1_fr[4] <= qmul(in_item.def_00, in_item.rate_00);
      s1_fr[5] <= qmul(in_item.def_10, in_item.rate_10);
      s1_fr[6] <= qmul(in_item.def_01, in_item.rate_01);
      s1_fr[7] <= qmul(in_item.def_11, in_item.rate_11);
      s1_wb    <= qmul({1'b0, in_item.weight}, beta);
      s1_mua   <= qmul(mu, s1_ld_ab);
      // stage 2
      s2_f    <= s1_f;
      s2_w    <= s1_w;
      s2_dec  <= qsub(qsub(s1_ff03, s1_ff12), alpha);
      s2_mf   <= s1_mf;
      s2_n    <= qadd(qadd(s1_sq[0], s1_sq[1]), qadd(s1_sq[2], s1_sq[3]));
      for (int i = 0; i < 4; i++) s2_half[i] <= qhalf(s1_fr[i]);
      s2_a    <= qadd(s1_fr[4], s1_fr[5]);
      s2_b    <= qadd(s1_fr[6], s1_fr[7]);
      s2_wb   <= s1_wb;
      s2_mua  <= s1_mua;
      // stage 3
      s3_f    <= s2_f;
      s3_w    <= s2_w;
      s3_ld   <= qmul(lam, s2_dec);
      s3_mf   <= s2_mf;
      s3_nmu  <= qmul(mu, s2_n);
      s3_dd   <= qmul(s2_dec, s2_dec);
      s3_s    <= qadd(qadd(s2_half[0], s2_half[1]), qadd(s2_half[2], s2_half[3]));
      s3_a    <= s2_a;
      s3_b    <= s2_b;
      s3_wb   <= s2_wb;
      s3_mua  <= s2_mua;
      // stage 4: cofactor products and viscous terms
      s4_w    <= s3_w;
      s4_p[0] <= qsub(qneg(s3_mf[0]), qmul(s3_ld, s3_f[3]));
      s4_p[1] <= qsub(qneg(s3_mf[1]), qmul(s3_ld, qneg(s3_f[2])));
      s4_p[2] <= qsub(qneg(s3_mf[2]), qmul(s3_ld, qneg(s3_f[1])));
      s4_p[3] <= qsub(qneg(s3_mf[3]), qmul(s3_ld, s3_f[0]));
      s4_fa[0] <= qmul(s3_f[0], s3_a);
      s4_fa[1] <= qmul(s3_f[1], s3_b);
      s4_fa[2] <= qmul(s3_f[2], s3_a);
      s4_fa[3] <= qmul(s3_f[3], s3_b);
      s4_fs[0] <= qmul(s3_f[1], s3_s);
      s4_fs[1] <= qmul(s3_f[0], s3_s);
      s4_fs[2] <= qmul(s3_f[3], s3_s);
      s4_fs[3] <= qmul(s3_f[2], s3_s);
      s4_wb   <= s3_wb;
      s4_e0   <= qadd(s3_nmu, qmul(lam, s3_dd));
      // stage 5
      s5_w    <= s4_w;
      s5_p    <= s4_p;
      for (int i = 0; i < 4; i++) s5_d[i] <= qadd(qtwice(s4_fa[i]), s4_fs[i]);
      s5_wb   <= s4_wb;
      s5_e    <= qsub(s4_e0, s3_mua_d);
      // stage 6
      for (int i = 0; i < 4; i++) begin
        s6_f[i]  <= qmul(s5_w, s5_p[i]);
        s6_wd[i] <= qmul(s5_wb, s5_d[i]);
      end
      s6_we   <= qmul(s5_w, s5_e);
      // stage 7
      for (int i = 0; i < 4; i++)
        s7_f[i] <= damp[5] ? qsub(s6_f[i], s6_wd[i]) : s6_f[i];
      s7_e    <= qhalf(s6_we);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) s3_mua_d <= s3_mua;
  end

  assign out_valid = vld[Stages-1];
  assign out_item.force_00    = s7_f[0];
  assign out_item.force_01    = s7_f[1];
  assign out_item.force_10    = s7_f[2];
  assign out_item.force_11    = s7_f[3];
  assign out_item.energy_term = s7_e;
endmodule
